>>> rtl/sbd_pkg.sv
`timescale 1ns / 1ps

package sbd_pkg;

  // fixed field widths
  localparam int IN_W   = 16;
  localparam int OUT_W  = 17;
  localparam int REG_W  = 18;
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;
  localparam int IDX_W  = 3;

  typedef logic [IDX_W-1:0] reg_idx_t;

  // register indexes, byte address is 4 * index
  localparam reg_idx_t REG_GAIN_SCALE = 3'd0;
  localparam reg_idx_t REG_COEF_ZERO  = 3'd1;
  localparam reg_idx_t REG_COEF_R2    = 3'd2;
  localparam reg_idx_t REG_COEF_R4    = 3'd3;
  localparam reg_idx_t REG_COEF_R6    = 3'd4;

  // reset values, unsigned Q2.16
  localparam logic [REG_W-1:0] RST_GAIN_SCALE = 18'd46811;
  localparam logic [REG_W-1:0] RST_COEF_ZERO  = 18'd65536;
  localparam logic [REG_W-1:0] RST_COEF_R2    = 18'd14418;
  localparam logic [REG_W-1:0] RST_COEF_R4    = 18'd15073;
  localparam logic [REG_W-1:0] RST_COEF_R6    = 18'd0;

endpackage

>>> rtl/sbd_in_if.sv
`timescale 1ns / 1ps

interface sbd_in_if import sbd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_x;
  logic [IN_W-1:0] sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink (input valid, input sample_x, input sample_y, output ready);
endinterface

>>> rtl/sbd_out_if.sv
`timescale 1ns / 1ps

interface sbd_out_if import sbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] warped_x;
  logic [OUT_W-1:0] warped_y;

  modport source (output valid, output warped_x, output warped_y, input ready);
  modport sink (input valid, input warped_x, input warped_y, output ready);
endinterface

>>> rtl/stereo_barrel_distortion.sv
`timescale 1ns / 1ps
// Stereo barrel distortion warp for a side-by-side stereo pixel stream.
// in_chan carries one sample (sample_x, sample_y, unsigned Q0.16) per beat;
// sample_x below one half is the left eye, the rest the right eye.
// out_chan carries one warped position (warped_x, warped_y, unsigned Q1.16)
// per input beat, in input order.
// The APB port (psel .. prdata) holds gain_scale and the four polynomial
// coefficients at byte addresses 0, 4, 8, 12 and 16; pready is always high.
// Write the registers only while no sample is in flight.
// An accepted input beat passes through the ten register stages on its way
// to its output beat (eye coordinates, squares, r^2 sum, r^4, r^6,
// r^6 term, polynomial sum, gain product, coordinate product, clamp and output register).
// Throughput: one beat per cycle while out_chan is ready.
// When the receiver stalls, the whole pipeline holds and in_chan.ready drops;
// a bubble stage advances as soon as the output register is free again.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// coefficients.
module stereo_barrel_distortion import sbd_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  sbd_in_if.sink            in_chan,
  sbd_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int F    = FRAC_BITS;
  localparam int SHL  = (F >= 16) ? F - 16 : 0;
  localparam int SHR  = (F >= 16) ? 0 : 16 - F;
  localparam int NSTG = 9;

  localparam logic signed [F+10:0] ONE_WIDE     = $signed((F+11)'(1) << F);
  localparam logic signed [F+10:0] NEG_ONE_WIDE = -ONE_WIDE;
  localparam logic signed [F+1:0]  ONE_CLAMP    = $signed((F+2)'(1) << F);
  localparam logic        [F+1:0]  ONE_U        = (F+2)'(1) << F;
  localparam logic        [F:0]    HALF_U       = (F+1)'(1) << (F-1);

  // unsigned Q0.16 input to F fraction bits
  function automatic logic [F-1:0] cvt_in(input logic [IN_W-1:0] v);
    logic [IN_W+SHL-1:0] t;
    t = (IN_W+SHL)'(v) << SHL;
    return F'(t >> SHR);
  endfunction

  // unsigned Q2.16 register to F fraction bits
  function automatic logic [F+1:0] cvt_reg(input logic [REG_W-1:0] v);
    logic [REG_W+SHL-1:0] t;
    t = (REG_W+SHL)'(v) << SHL;
    return (F+2)'(t >> SHR);
  endfunction

  // F fraction bits back to 16 fraction bits
  function automatic logic [OUT_W-1:0] cvt_out(input logic [F:0] v);
    logic [F+SHR:0] t;
    t = (F+SHR+1)'(v) << SHR;
    return OUT_W'(t >> SHL);
  endfunction

  // configuration registers
  logic [REG_W-1:0] gain_scale_r, coef_zero_r, coef_r2_r, coef_r4_r, coef_r6_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_scale_r <= RST_GAIN_SCALE;
      coef_zero_r  <= RST_COEF_ZERO;
      coef_r2_r    <= RST_COEF_R2;
      coef_r4_r    <= RST_COEF_R4;
      coef_r6_r    <= RST_COEF_R6;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_SCALE: gain_scale_r <= pwdata[REG_W-1:0];
        REG_COEF_ZERO:  coef_zero_r  <= pwdata[REG_W-1:0];
        REG_COEF_R2:    coef_r2_r    <= pwdata[REG_W-1:0];
        REG_COEF_R4:    coef_r4_r    <= pwdata[REG_W-1:0];
        REG_COEF_R6:    coef_r6_r    <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_GAIN_SCALE: prdata = APB_DW'(gain_scale_r);
      REG_COEF_ZERO:  prdata = APB_DW'(coef_zero_r);
      REG_COEF_R2:    prdata = APB_DW'(coef_r2_r);
      REG_COEF_R4:    prdata = APB_DW'(coef_r4_r);
      REG_COEF_R6:    prdata = APB_DW'(coef_r6_r);
      default:        prdata = '0;
    endcase
  end

  // coefficients in internal format
  logic [F+1:0] gain_f, c0_f, c2_f, c4_f, c6_f;
  assign gain_f = cvt_reg(gain_scale_r);
  assign c0_f   = cvt_reg(coef_zero_r);
  assign c2_f   = cvt_reg(coef_r2_r);
  assign c4_f   = cvt_reg(coef_r4_r);
  assign c6_f   = cvt_reg(coef_r6_r);

  // pipeline advance: whole pipe moves while the output register can take a beat
  logic            adv;
  logic [NSTG:1]   vld_r;
  logic            out_vld_r;

  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NSTG-1:1], in_chan.valid};
      out_vld_r <= vld_r[NSTG];
    end
  end

  // stage 1: eye-centered coordinates
  logic [F-1:0]     x_f, y_f;
  logic signed [F:0] ex_nxt, ey_nxt;
  assign x_f    = cvt_in(in_chan.sample_x);
  assign y_f    = cvt_in(in_chan.sample_y);
  // 4x - 1 and 2y - 1 by flipping the top bit; the eye half drops out of x
  assign ex_nxt = {~x_f[F-2], x_f[F-3:0], 2'b00};
  assign ey_nxt = {~y_f[F-1], y_f[F-2:0], 1'b0};

  logic signed [F:0] ex_r [1:8];
  logic signed [F:0] ey_r [1:8];
  logic              rt_r [1:9];
  logic              out_rt_r;

  // stage 2: squares
  logic signed [2*F+1:0] sqx_p, sqy_p;
  logic [2*F:0]          sqx_r, sqy_r;
  assign sqx_p = ex_r[1] * ex_r[1];
  assign sqy_p = ey_r[1] * ey_r[1];

  // stage 3: r^2
  logic [2*F+1:0] r2_sum;
  logic [F+1:0]   r2_r3, r2_r4;
  assign r2_sum = (2*F+2)'(sqx_r) + (2*F+2)'(sqy_r);

  // stage 4: r^4 and r^2 term
  logic [2*F+3:0] r4_p, t2_p;
  logic [F+2:0]   r4_r;
  logic [F+3:0]   t2_r4, t2_r5;
  assign r4_p = r2_r3 * r2_r3;
  assign t2_p = c2_f * r2_r3;

  // stage 5: r^6 and r^4 term
  logic [2*F+4:0] r6_p, t4_p;
  logic [F+3:0]   r6_r;
  logic [F+4:0]   t4_r;
  assign r6_p = r4_r * r2_r4;
  assign t4_p = c4_f * r4_r;

  // stage 6: r^6 term and partial sum
  logic [2*F+5:0] t6_p;
  logic [F+5:0]   t6_r, part_r;
  assign t6_p = c6_f * r6_r;

  // stage 7: polynomial
  logic [F+6:0] poly_r;

  // stage 8: gain
  logic [2*F+8:0] fr_p;
  logic [F+8:0]   fr_r;
  assign fr_p = gain_f * poly_r;

  // stage 9: scaled coordinates, floored back to F fraction bits
  logic signed [2*F+10:0] px_p, py_p;
  logic signed [F+10:0]   rx_r, ry_r;
  assign px_p = ex_r[8] * $signed({1'b0, fr_r});
  assign py_p = ey_r[8] * $signed({1'b0, fr_r});

  // stage 10: clamp to [-1,1] and map back to the eye's half
  logic signed [F+1:0] cx, cy;
  logic [F+1:0]        ux, uy;
  logic [F:0]          ox, oy;
  logic [OUT_W-1:0]    wx_r, wy_r;

  always_comb begin
    if (rx_r > ONE_WIDE) begin
      cx = ONE_CLAMP;
    end else if (rx_r < NEG_ONE_WIDE) begin
      cx = -ONE_CLAMP;
    end else begin
      cx = rx_r[F+1:0];
    end
    if (ry_r > ONE_WIDE) begin
      cy = ONE_CLAMP;
    end else if (ry_r < NEG_ONE_WIDE) begin
      cy = -ONE_CLAMP;
    end else begin
      cy = ry_r[F+1:0];
    end
    ux = $unsigned(cx) + ONE_U;
    uy = $unsigned(cy) + ONE_U;
    ox = {1'b0, ux[F+1:2]} + (rt_r[9] ? HALF_U : '0);
    oy = ux[F+1:1] & '0 | uy[F+1:1];
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r[1]  <= ex_nxt;
      ey_r[1]  <= ey_nxt;
      rt_r[1]  <= in_chan.sample_x[IN_W-1];
      for (int i = 2; i <= 8; i++) begin
        ex_r[i] <= ex_r[i-1];
        ey_r[i] <= ey_r[i-1];
      end
      for (int i = 2; i <= 9; i++) begin
        rt_r[i] <= rt_r[i-1];
      end
      sqx_r    <= sqx_p[2*F:0];
      sqy_r    <= sqy_p[2*F:0];
      r2_r3    <= r2_sum[2*F+1:F];
      r2_r4    <= r2_r3;
      r4_r     <= r4_p[2*F+2:F];
      t2_r4    <= t2_p[2*F+3:F];
      r6_r     <= r6_p[2*F+3:F];
      t4_r     <= t4_p[2*F+4:F];
      t2_r5    <= t2_r4;
      t6_r     <= t6_p[2*F+5:F];
      part_r   <= (F+6)'(c0_f) + (F+6)'(t2_r5) + (F+6)'(t4_r);
      poly_r   <= (F+7)'(part_r) + (F+7)'(t6_r);
      fr_r     <= fr_p[2*F+8:F];
      rx_r     <= px_p[2*F+10:F];
      ry_r     <= py_p[2*F+10:F];
      wx_r     <= cvt_out(ox);
      wy_r     <= cvt_out(oy);
      out_rt_r <= rt_r[9];
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.warped_x = wx_r;
  assign out_chan.warped_y = wy_r;

  // results stay inside the unit frame
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (wx_r <= OUT_W'(65536)) && (wy_r <= OUT_W'(65536)))
    else $error("warped position outside the frame");

  // each result lands in its own eye's half
  a_eye_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_rt_r ? (wx_r >= OUT_W'(32768)) : (wx_r <= OUT_W'(32768))))
    else $error("warped x left its eye's half");

  // a stall freezes the valid bits of every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && out_vld_r)
    else $error("pipeline moved during a stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0) && !out_vld_r)
    else $error("pipeline not empty after reset");

endmodule
